>>> hdl/sqe_pkg.sv
// Shared types and codes for the stack/queue engine.
`timescale 1ns / 1ps

package sqe_pkg;

  localparam int DATA_W        = 32;
  localparam int FUNC_W        = 3;
  localparam int STATUS_W      = 3;
  localparam int ADDR_W        = 3;
  localparam int DEPTH_DEFAULT = 64;

  // operation codes carried by func
  localparam logic [FUNC_W-1:0] FUNC_PUSH  = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_PRINT = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_PEEK  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_POP   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_SWAP  = 3'd4;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_DONE       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ELEM       = 3'd1;
  localparam logic [STATUS_W-1:0] ST_PEEK_EMPTY = 3'd2;
  localparam logic [STATUS_W-1:0] ST_POP_EMPTY  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_SWAP_SHORT = 3'd4;
  localparam logic [STATUS_W-1:0] ST_PUSH_FULL  = 3'd5;

  // register word index (paddr[2]) of queue_mode
  localparam logic REG_QUEUE_MODE = 1'b0;

  // command broadcast to every cell of the chain
  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_PUSH_TOP,
    CMD_PUSH_TAIL,
    CMD_POP,
    CMD_SWAP,
    CMD_ROTATE
  } cell_cmd_t;

endpackage

>>> hdl/stack_queue_engine.sv
// Top level of the stack/queue engine: control, register port and cell chain.
// A result beat is loaded into the output register at the edge that accepts its item;
// a nonempty print all loads its first element from the print state.
// Push, peek, pop, swap and unknown codes are taken back to back while the receiver
// does not stall. Print all enters the print state, then emits its fill_count elements
// one per cycle while the receiver does not stall, and takes no item meanwhile.
// Reset clears the fill count, the print state, queue_mode and the output valid flag;
// cell contents and result fields are not reset.
`timescale 1ns / 1ps

module stack_queue_engine #(
  parameter int DEPTH = sqe_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  // input item channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [sqe_pkg::FUNC_W-1:0]        func,
  input  logic signed [sqe_pkg::DATA_W-1:0] push_value,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [sqe_pkg::DATA_W-1:0] data,
  output logic [sqe_pkg::STATUS_W-1:0]      status,
  output logic                              last,
  // register port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sqe_pkg::ADDR_W-1:0]        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  // count width holds the values 0..DEPTH
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] ONE  = CNT_W'(1);
  localparam logic [CNT_W-1:0] TWO  = CNT_W'(2);

  typedef enum logic {
    S_IDLE,
    S_PRINT
  } state_t;

  state_t state;
  logic [CNT_W-1:0] fill_count;
  logic [CNT_W-1:0] print_cnt;
  logic             queue_mode;

  // ---------------------------------------------------------------------------
  // Register port: single mode bit at word 0, no wait states.
  // ---------------------------------------------------------------------------
  logic cfg_write;
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      queue_mode <= 1'b0;
    end else if (cfg_write && paddr[2] == sqe_pkg::REG_QUEUE_MODE) begin
      queue_mode <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == sqe_pkg::REG_QUEUE_MODE) ? {31'd0, queue_mode} : 32'd0;

  // ---------------------------------------------------------------------------
  // Cell chain. Cell 0 is the top; the chain is packed, so element i of the
  // logical order always lives in cell i. A stack push shifts toward the tail,
  // a queue push lands in the cell at fill_count, a pop shifts toward the top,
  // and print rotates the live part of the chain so each element passes cell 0.
  // ---------------------------------------------------------------------------
  sqe_pkg::cell_cmd_t cmd;
  logic signed [sqe_pkg::DATA_W-1:0] cell_val [DEPTH];
  logic signed [sqe_pkg::DATA_W-1:0] head;

  assign head = cell_val[0];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [sqe_pkg::DATA_W-1:0] prev_v;
    logic signed [sqe_pkg::DATA_W-1:0] next_v;

    if (g == 0) begin : g_first
      assign prev_v = push_value;
    end else begin : g_mid_prev
      assign prev_v = cell_val[g-1];
    end

    if (g == DEPTH - 1) begin : g_end
      assign next_v = cell_val[g];
    end else begin : g_mid_next
      assign next_v = cell_val[g+1];
    end

    sqe_cell #(
      .INDEX (g),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .fill       (fill_count),
      .push_value (push_value),
      .prev_val   (prev_v),
      .next_val   (next_v),
      .head_val   (head),
      .val        (cell_val[g])
    );
  end

  // ---------------------------------------------------------------------------
  // Control. The output register frees when it is empty or its beat leaves.
  // Items are taken only in IDLE; print holds the input side until its last beat.
  // ---------------------------------------------------------------------------
  logic out_free;
  logic in_take;
  logic print_beat;
  logic print_last;

  // result of a taken item; a nonempty print gives no beat here
  logic                              take_beat;
  logic signed [sqe_pkg::DATA_W-1:0] take_data;
  logic [sqe_pkg::STATUS_W-1:0]      take_status;

  assign out_free   = !out_valid || !out_stall;
  assign in_stall   = (state != S_IDLE) || !out_free;
  assign in_take    = in_valid && !in_stall;
  assign print_beat = (state == S_PRINT) && out_free;
  assign print_last = (print_cnt + ONE) == fill_count;

  always_comb begin
    cmd = sqe_pkg::CMD_HOLD;
    if (in_take) begin
      case (func)
        sqe_pkg::FUNC_PUSH: begin
          if (fill_count != FULL) cmd = queue_mode ? sqe_pkg::CMD_PUSH_TAIL
                                                   : sqe_pkg::CMD_PUSH_TOP;
        end
        sqe_pkg::FUNC_POP: begin
          if (fill_count != '0) cmd = sqe_pkg::CMD_POP;
        end
        sqe_pkg::FUNC_SWAP: begin
          if (fill_count >= TWO) cmd = sqe_pkg::CMD_SWAP;
        end
        default: begin
          cmd = sqe_pkg::CMD_HOLD;
        end
      endcase
    end else if (print_beat) begin
      cmd = sqe_pkg::CMD_ROTATE;
    end
  end

  always_comb begin
    take_beat   = 1'b1;
    take_data   = '0;
    take_status = sqe_pkg::ST_DONE;
    case (func)
      sqe_pkg::FUNC_PUSH: begin
        if (fill_count == FULL) take_status = sqe_pkg::ST_PUSH_FULL;
      end
      sqe_pkg::FUNC_PRINT: begin
        // nonempty: the element beats come from the print state
        if (fill_count != '0) take_beat = 1'b0;
      end
      sqe_pkg::FUNC_PEEK: begin
        if (fill_count == '0) begin
          take_status = sqe_pkg::ST_PEEK_EMPTY;
        end else begin
          take_status = sqe_pkg::ST_ELEM;
          take_data   = head;
        end
      end
      sqe_pkg::FUNC_POP: begin
        if (fill_count == '0) take_status = sqe_pkg::ST_POP_EMPTY;
      end
      sqe_pkg::FUNC_SWAP: begin
        if (fill_count < TWO) take_status = sqe_pkg::ST_SWAP_SHORT;
      end
      default: begin
        take_status = sqe_pkg::ST_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill_count <= '0;
      print_cnt  <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (in_take) begin
        out_valid <= take_beat;
        data      <= take_data;
        status    <= take_status;
        last      <= 1'b1;
        case (func)
          sqe_pkg::FUNC_PUSH: begin
            if (fill_count != FULL) fill_count <= fill_count + ONE;
          end
          sqe_pkg::FUNC_PRINT: begin
            if (fill_count != '0) begin
              state     <= S_PRINT;
              print_cnt <= '0;
            end
          end
          sqe_pkg::FUNC_POP: begin
            if (fill_count != '0) fill_count <= fill_count - ONE;
          end
          default: begin
          end
        endcase
      end else if (print_beat) begin
        out_valid <= 1'b1;
        data      <= head;
        status    <= sqe_pkg::ST_ELEM;
        last      <= print_last;
        print_cnt <= print_cnt + ONE;
        if (print_last) state <= S_IDLE;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FULL)
    else $error("fill count beyond depth");

  a_print_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == S_PRINT) |-> (print_cnt < fill_count))
    else $error("print counter ran past the fill count");

  a_mid_beat_elem: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last) |-> (status == sqe_pkg::ST_ELEM))
    else $error("non-final beat that is not an element");

  a_print_no_change: assert property (@(posedge clk) disable iff (rst)
    (state == S_PRINT) |=> $stable(fill_count))
    else $error("fill count changed during print");

endmodule

>>> hdl/sqe_cell.sv
// One storage cell of the element chain; cell 0 holds the top element.
`timescale 1ns / 1ps

module sqe_cell #(
  parameter int INDEX = 0,
  parameter int CNT_W = 7
) (
  input  logic                             clk,
  input  sqe_pkg::cell_cmd_t               cmd,
  input  logic [CNT_W-1:0]                 fill,
  input  logic signed [sqe_pkg::DATA_W-1:0] push_value,
  input  logic signed [sqe_pkg::DATA_W-1:0] prev_val,
  input  logic signed [sqe_pkg::DATA_W-1:0] next_val,
  input  logic signed [sqe_pkg::DATA_W-1:0] head_val,
  output logic signed [sqe_pkg::DATA_W-1:0] val
);

  localparam logic [CNT_W-1:0] IDX      = CNT_W'(INDEX);
  localparam logic [CNT_W-1:0] IDX_PLUS = CNT_W'(INDEX + 1);

  logic signed [sqe_pkg::DATA_W-1:0] val_next;

  always_comb begin
    val_next = val;
    case (cmd)
      sqe_pkg::CMD_PUSH_TOP: begin
        val_next = prev_val;
      end
      sqe_pkg::CMD_PUSH_TAIL: begin
        if (fill == IDX) val_next = push_value;
      end
      sqe_pkg::CMD_POP: begin
        val_next = next_val;
      end
      sqe_pkg::CMD_SWAP: begin
        if (INDEX == 0) val_next = next_val;
        else if (INDEX == 1) val_next = prev_val;
      end
      sqe_pkg::CMD_ROTATE: begin
        // the tail element takes the old head, everything above it moves up
        if (fill == IDX_PLUS) val_next = head_val;
        else if (fill > IDX_PLUS) val_next = next_val;
      end
      default: begin
        val_next = val;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

>>> bench/sqe_checker.sv
// Scoreboard for the stack/queue engine: predicts every result beat and compares it.
`timescale 1ns / 1ps

module sqe_checker #(
  parameter int DEPTH = sqe_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [sqe_pkg::FUNC_W-1:0]        func,
  input  logic signed [sqe_pkg::DATA_W-1:0] push_value,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic signed [sqe_pkg::DATA_W-1:0] data,
  input  logic [sqe_pkg::STATUS_W-1:0]      status,
  input  logic                              last,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sqe_pkg::ADDR_W-1:0]        paddr,
  input  logic [31:0]                       pwdata,
  input  logic                              pready,
  output int unsigned                       fail_count,
  output int unsigned                       pending
);

  typedef struct packed {
    logic [sqe_pkg::DATA_W-1:0]   data;
    logic [sqe_pkg::STATUS_W-1:0] status;
    logic                         last;
  } result_t;

  result_t                    result_q[$];
  logic [sqe_pkg::DATA_W-1:0] cells [DEPTH];
  int unsigned                head;
  int unsigned                fill;
  logic                       queue_mode;
  int unsigned                errors;

  function automatic int unsigned slot(input int unsigned off);
    return (head + off) % DEPTH;
  endfunction

  function automatic void add_result(input logic [sqe_pkg::DATA_W-1:0] d,
                                     input logic [sqe_pkg::STATUS_W-1:0] s,
                                     input logic l);
    result_t r;
    r.data   = d;
    r.status = s;
    r.last   = l;
    result_q.push_back(r);
  endfunction

  function automatic void predict_op(input logic [sqe_pkg::FUNC_W-1:0] f,
                                     input logic [sqe_pkg::DATA_W-1:0] v);
    logic [sqe_pkg::DATA_W-1:0] tmp;
    case (f)
      sqe_pkg::FUNC_PUSH: begin
        if (fill >= DEPTH) begin
          add_result('0, sqe_pkg::ST_PUSH_FULL, 1'b1);
        end else begin
          if (queue_mode) begin
            cells[slot(fill)] = v;
          end else begin
            head = slot(DEPTH - 1);
            cells[head] = v;
          end
          fill++;
          add_result('0, sqe_pkg::ST_DONE, 1'b1);
        end
      end
      sqe_pkg::FUNC_PRINT: begin
        if (fill == 0) begin
          add_result('0, sqe_pkg::ST_DONE, 1'b1);
        end else begin
          for (int unsigned i = 0; i < fill; i++)
            add_result(cells[slot(i)], sqe_pkg::ST_ELEM, (i + 1 == fill));
        end
      end
      sqe_pkg::FUNC_PEEK: begin
        if (fill == 0) add_result('0, sqe_pkg::ST_PEEK_EMPTY, 1'b1);
        else add_result(cells[head], sqe_pkg::ST_ELEM, 1'b1);
      end
      sqe_pkg::FUNC_POP: begin
        if (fill == 0) begin
          add_result('0, sqe_pkg::ST_POP_EMPTY, 1'b1);
        end else begin
          head = slot(1);
          fill--;
          add_result('0, sqe_pkg::ST_DONE, 1'b1);
        end
      end
      sqe_pkg::FUNC_SWAP: begin
        if (fill < 2) begin
          add_result('0, sqe_pkg::ST_SWAP_SHORT, 1'b1);
        end else begin
          tmp = cells[slot(0)];
          cells[slot(0)] = cells[slot(1)];
          cells[slot(1)] = tmp;
          add_result('0, sqe_pkg::ST_DONE, 1'b1);
        end
      end
      default: add_result('0, sqe_pkg::ST_DONE, 1'b1);
    endcase
  endfunction

  function automatic void compare_result();
    result_t want;
    if (result_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected result beat: expected none, actual data %h status %0d last %b",
               $realtime, data, status, last);
      return;
    end
    want = result_q.pop_front();
    if (data !== want.data) begin
      errors++;
      $display("%0t: data mismatch: expected %h actual %h", $realtime, want.data, data);
    end
    if (status !== want.status) begin
      errors++;
      $display("%0t: status mismatch: expected %0d actual %0d", $realtime, want.status, status);
    end
    if (last !== want.last) begin
      errors++;
      $display("%0t: last mismatch: expected %b actual %b", $realtime, want.last, last);
    end
  endfunction

  initial begin
    errors     = 0;
    fail_count = 0;
    pending    = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      head       = 0;
      fill       = 0;
      queue_mode = 1'b0;
      result_q.delete();
    end else begin
      if (out_valid && !out_stall) compare_result();
      if (in_valid && !in_stall) predict_op(func, push_value);
      if (psel && penable && pwrite && pready && paddr[2] == sqe_pkg::REG_QUEUE_MODE)
        queue_mode = pwdata[0];
    end
    fail_count <= errors;
    pending    <= result_q.size();
  end

endmodule

>>> bench/tb_stack_queue_engine.sv
// Top of the stack/queue engine testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_stack_queue_engine;

  localparam int DEPTH           = sqe_pkg::DEPTH_DEFAULT;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int ITEMS_PER_PHASE = 75;

  typedef logic [sqe_pkg::FUNC_W-1:0] func_t;

  // func codes 5..7 have no operation behind them
  localparam func_t FUNC_SPARE_LO = 3'd5;
  localparam func_t FUNC_SPARE_HI = 3'd7;

  // byte addresses of register 0 (queue_mode) and of the unused word above it
  localparam logic [sqe_pkg::ADDR_W-1:0] ADDR_QUEUE_MODE = {sqe_pkg::REG_QUEUE_MODE, 2'b00};
  localparam logic [sqe_pkg::ADDR_W-1:0] ADDR_SPARE      = {~sqe_pkg::REG_QUEUE_MODE, 2'b00};

  localparam logic signed [sqe_pkg::DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [sqe_pkg::DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

  logic                              clk;
  logic                              rst;
  logic                              in_valid;
  logic                              in_stall;
  func_t                             func;
  logic signed [sqe_pkg::DATA_W-1:0] push_value;
  logic                              out_valid;
  logic                              out_stall;
  logic signed [sqe_pkg::DATA_W-1:0] data;
  logic [sqe_pkg::STATUS_W-1:0]      status;
  logic                              last;
  logic                              psel;
  logic                              penable;
  logic                              pwrite;
  logic [sqe_pkg::ADDR_W-1:0]        paddr;
  logic [31:0]                       pwdata;
  logic [31:0]                       prdata;
  logic                              pready;

  int unsigned sb_fail_count;
  int unsigned sb_pending;

  // per-cycle odds (out of 100) of an idle sender cycle and of a receiver stall
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned cycle_count;

  stack_queue_engine #(.DEPTH(DEPTH)) uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .push_value(push_value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .data      (data),
    .status    (status),
    .last      (last),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // The scoreboard sees every engine pin but prdata and keeps its own copy of the store.
  sqe_checker #(.DEPTH(DEPTH)) sb (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .push_value(push_value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .data      (data),
    .status    (status),
    .last      (last),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .pready    (pready),
    .fail_count(sb_fail_count),
    .pending   (sb_pending)
  );

  // 12 ns period: 6 ns high, 6 ns low
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver: stall each cycle with the odds of the current phase.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog: end the run as failed if it runs far past the slowest correct run.
  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
    $display("tb_stack_queue_engine: errors");
    $finish;
  end

  // Present one input beat and hold it until the engine takes it. Idle cycles go in front
  // of the beat; valid stays high straight into the next beat when no idle is drawn.
  task automatic send_item(input func_t f, input logic signed [sqe_pkg::DATA_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    func       <= f;
    push_value <= v;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and wait until the scoreboard holds no outstanding result.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb_pending != 0);
  endtask

  // Setup cycle, then access cycle; the write lands on the edge that sees pready.
  task automatic write_reg(input logic [sqe_pkg::ADDR_W-1:0] addr, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Random upper bits on pwdata; only bit 0 selects the mode.
  task automatic set_mode(input logic mode);
    write_reg(ADDR_QUEUE_MODE, {31'($urandom()), mode});
  endtask

  // Bias toward the extremes now and then, otherwise a full 32-bit random value.
  function automatic logic signed [sqe_pkg::DATA_W-1:0] rand_value();
    case ($urandom_range(9))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return '0;
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // Pushes with the given odds; the rest spread over the other operations and spare codes.
  function automatic func_t rand_func(input int unsigned push_pct);
    int unsigned pick;
    if ($urandom_range(99) < push_pct) return sqe_pkg::FUNC_PUSH;
    pick = $urandom_range(16);
    if (pick < 4) return sqe_pkg::FUNC_PRINT;
    if (pick < 8) return sqe_pkg::FUNC_PEEK;
    if (pick < 12) return sqe_pkg::FUNC_POP;
    if (pick < 16) return sqe_pkg::FUNC_SWAP;
    return func_t'($urandom_range(FUNC_SPARE_HI, FUNC_SPARE_LO));
  endfunction

  // Phase table: sender idle odds, receiver stall odds, mode and push odds.
  // The second phase pushes hard so the store fills up and push-full shows up.
  int unsigned phase_idle  [4] = '{0, 67, 0, 35};
  int unsigned phase_stall [4] = '{0, 0, 67, 35};
  logic        phase_mode  [4] = '{1'b0, 1'b1, 1'b1, 1'b0};
  int unsigned phase_push  [4] = '{60, 90, 30, 55};

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    func           = sqe_pkg::FUNC_PUSH;
    push_value     = '0;
    out_stall      = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    drain();

    // Directed, stack mode from reset: the error codes on an empty store first.
    send_item(sqe_pkg::FUNC_PRINT, '0);
    send_item(sqe_pkg::FUNC_PEEK, VAL_MAX);
    send_item(sqe_pkg::FUNC_POP, VAL_MIN);
    send_item(sqe_pkg::FUNC_SWAP, '1);
    // swap with a single element is still short
    send_item(sqe_pkg::FUNC_PUSH, VAL_MAX);
    send_item(sqe_pkg::FUNC_SWAP, '0);
    send_item(sqe_pkg::FUNC_PEEK, '0);
    send_item(sqe_pkg::FUNC_PUSH, VAL_MIN);
    send_item(sqe_pkg::FUNC_PUSH, '1);
    send_item(sqe_pkg::FUNC_PUSH, '0);
    send_item(sqe_pkg::FUNC_PRINT, '0);
    send_item(sqe_pkg::FUNC_SWAP, '0);
    send_item(sqe_pkg::FUNC_PEEK, '0);
    send_item(sqe_pkg::FUNC_POP, '0);
    // spare codes must leave the store alone and answer done
    send_item(FUNC_SPARE_LO, VAL_MAX);
    send_item(FUNC_SPARE_LO + 1'b1, VAL_MIN);
    send_item(FUNC_SPARE_HI, '1);
    send_item(sqe_pkg::FUNC_PRINT, '0);
    send_item(sqe_pkg::FUNC_POP, '0);
    send_item(sqe_pkg::FUNC_POP, '0);
    send_item(sqe_pkg::FUNC_POP, '0);
    send_item(sqe_pkg::FUNC_POP, '0);

    // Queue mode: pushes go to the tail.
    drain();
    set_mode(1'b1);
    send_item(sqe_pkg::FUNC_PUSH, 32'sd1);
    send_item(sqe_pkg::FUNC_PUSH, 32'sd2);
    send_item(sqe_pkg::FUNC_PUSH, 32'sd3);
    send_item(sqe_pkg::FUNC_PRINT, '0);

    // Flip back to stack mode with elements held; they stay where they are.
    drain();
    set_mode(1'b0);
    send_item(sqe_pkg::FUNC_PUSH, 32'sd4);
    send_item(sqe_pkg::FUNC_PRINT, '0);

    // A write to the word above queue_mode must change nothing.
    drain();
    write_reg(ADDR_SPARE, '1);
    send_item(sqe_pkg::FUNC_PUSH, 32'sd5);
    send_item(sqe_pkg::FUNC_PRINT, '0);

    // Random phases; each starts from an idle engine with a fresh mode write.
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      send_idle_pct  = phase_idle[ph];
      recv_stall_pct = phase_stall[ph];
      set_mode(phase_mode[ph]);
      for (int n = 0; n < ITEMS_PER_PHASE; n++)
        send_item(rand_func(phase_push[ph]), rand_value());
    end

    // Hold off until every result is back, then give the output register time to settle.
    drain();
    repeat (4) @(posedge clk);
    if (sb_fail_count == 0) begin
      $display("tb_stack_queue_engine: clean");
    end else begin
      $display("tb_stack_queue_engine: errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/sqe_pkg.sv
hdl/sqe_cell.sv
hdl/stack_queue_engine.sv
bench/sqe_checker.sv
bench/tb_stack_queue_engine.sv
